// ----- rtl/core/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// Holds the beat structs, command kinds and the controller/datapath links.
// Depends on nothing.
package tcw_pkg;

  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_CLEAR  = 3'd1;
  localparam logic [2:0] KIND_SETCUR = 3'd2;
  localparam logic [2:0] KIND_COLOR  = 3'd3;
  localparam logic [2:0] KIND_RGB    = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  localparam logic [7:0] NEWLINE_CODE  = 8'd10;
  localparam logic [7:0] SPACE_CODE    = 8'h20;
  localparam logic [7:0] RESET_COLOR   = 8'h07;
  localparam logic [7:0] CHANNEL_LIMIT = 8'd128;
  localparam logic [7:0] RGB_RED       = 8'h04;
  localparam logic [7:0] RGB_GREEN     = 8'h02;
  localparam logic [7:0] RGB_BLUE      = 8'h01;
  localparam logic [7:0] RGB_BRIGHT    = 8'h08;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        char_code;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic [7:0]        new_color;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
  } in_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [7:0]  current_color;
    logic [15:0] cell_value;
    logic        position_ok;
  } out_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic load;
    logic read_out;
  } cmd_t;

  typedef struct packed {
    logic kind_read;
    logic kind_clear;
    logic sweep_last;
  } sta_t;

endpackage

// ----- rtl/core/text_console_writer_core.sv -----
// Top level of the text console writer: a text screen store with a cursor.
// Commands enter on the in channel and every command returns one result beat
// on the out channel with the cursor and color after the command.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Write char, set cursor, set color and RGB color register their result at the
// accepting edge, and the next command may follow at once.
// Read cell goes through the registered cell memory read, then the result register.
// Clear returns its result at once, then sweeps the memory one cell per cycle
// over all COLUMNS*ROWS cells, with the input stalled.
// After reset the same sweep writes a grey space into every cell, so the input
// stays stalled until the sweep has covered all 2000 cells at the default size.
// A command is only taken while the result register is empty or being emptied,
// so a stall on the out channel holds the result and stalls the in channel.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
module text_console_writer_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tcw_pkg::in_t  in_beat,
  output logic          out_valid,
  input  logic          out_stall,
  output tcw_pkg::out_t out_beat
);
  import tcw_pkg::*;

  cmd_t cmd;
  sta_t sta;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sta       (sta),
    .cmd       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (in_beat),
    .cmd      (cmd),
    .sta      (sta),
    .out_beat (out_beat)
  );

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// Controller state machine for the text console writer.
// Sequences command beats, screen sweeps and cell reads; drives the handshakes.
// Depends on tcw_pkg.
module tcw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  tcw_pkg::sta_t sta,
  output tcw_pkg::cmd_t cmd
);
  import tcw_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       can_take;
  logic       accept;

  assign can_take = (state == ST_IDLE) && (!out_valid || !out_stall);
  assign in_stall = !can_take;
  assign accept   = in_valid && can_take;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && sta.kind_read) begin
          state_next = ST_READ;
        end else if (accept && sta.kind_clear) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sta.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.accept     = accept;
    cmd.sweep      = (state == ST_SWEEP);
    cmd.read_out   = (state == ST_READ);
    cmd.load       = (accept && !sta.kind_read) || (state == ST_READ);
    out_valid_next = out_valid && out_stall;
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (state == ST_SWEEP) && !out_valid)
    else $error("reset does not start the screen sweep");

  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> (out_valid || state == ST_READ))
    else $error("accepted beat produced no result path");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_IDLE) && out_valid)
    else $error("cell read did not deliver a result");

  a_sweep_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) && !sta.sweep_last |=> (state == ST_SWEEP) && in_stall)
    else $error("sweep left early or input opened during sweep");
`endif

endmodule

// ----- rtl/core/tcw_datapath.sv -----
// Datapath for the text console writer: cursor, color, cell memory and result register.
// Follows the commands of tcw_ctrl and reports decoded kind and sweep progress.
// Depends on tcw_pkg.
module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  tcw_pkg::in_t  in_beat,
  input  tcw_pkg::cmd_t cmd,
  output tcw_pkg::sta_t sta,
  output tcw_pkg::out_t out_beat
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [15:0]   mem [CELLS];
  logic [6:0]    col;
  logic [4:0]    row;
  logic [7:0]    color;
  logic [AW-1:0] sweep_addr;
  logic [15:0]   rd_data;
  logic          rd_ok;

  logic [6:0]    col_next;
  logic [4:0]    row_next;
  logic [7:0]    color_next;
  logic [7:0]    col_inc;
  logic [5:0]    row_inc;
  logic [5:0]    row_wrap;
  logic          in_screen;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rgb_color;

  assign in_screen = !in_beat.pos_x[7] && ({1'b0, in_beat.pos_x[6:0]} < 8'(COLUMNS))
                  && !in_beat.pos_y[7] && ({1'b0, in_beat.pos_y[6:0]} < 8'(ROWS));

  assign wr_addr = AW'(row) * AW'(COLUMNS) + AW'(col);
  assign rd_addr = AW'(in_beat.pos_y[4:0]) * AW'(COLUMNS) + AW'(in_beat.pos_x[6:0]);

  assign col_inc  = {1'b0, col} + 8'd1;
  assign row_inc  = {1'b0, row} + 6'd1;
  assign row_wrap = (row_inc >= 6'(ROWS)) ? 6'd0 : row_inc;

  assign wr_en = cmd.accept && (in_beat.kind == KIND_WRITE)
              && (in_beat.char_code != NEWLINE_CODE);

  always_comb begin
    rgb_color = 8'd0;
    if (in_beat.red > CHANNEL_LIMIT) begin
      rgb_color = rgb_color | RGB_RED;
    end
    if (in_beat.green > CHANNEL_LIMIT) begin
      rgb_color = rgb_color | RGB_GREEN;
    end
    if (in_beat.blue > CHANNEL_LIMIT) begin
      rgb_color = rgb_color | RGB_BLUE;
    end
    if (rgb_color != 8'd0) begin
      rgb_color = rgb_color | RGB_BRIGHT;
    end
  end

  always_comb begin
    col_next   = col;
    row_next   = row;
    color_next = color;
    unique case (in_beat.kind)
      KIND_WRITE: begin
        if (in_beat.char_code == NEWLINE_CODE || col_inc >= 8'(COLUMNS)) begin
          col_next = 7'd0;
          row_next = row_wrap[4:0];
        end else begin
          col_next = col_inc[6:0];
        end
      end
      KIND_CLEAR: begin
        col_next = 7'd0;
        row_next = 5'd0;
      end
      KIND_SETCUR: begin
        if (in_screen) begin
          col_next = in_beat.pos_x[6:0];
          row_next = in_beat.pos_y[4:0];
        end
      end
      KIND_COLOR: begin
        color_next = in_beat.new_color;
      end
      KIND_RGB: begin
        color_next = rgb_color;
      end
      default: begin
        col_next = col;
      end
    endcase
  end

  assign sta.kind_read  = (in_beat.kind == KIND_READ);
  assign sta.kind_clear = (in_beat.kind == KIND_CLEAR);
  assign sta.sweep_last = (sweep_addr == AW'(CELLS - 1));

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[sweep_addr] <= {color, SPACE_CODE};
    end else if (wr_en) begin
      mem[wr_addr] <= {color, in_beat.char_code};
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= 7'd0;
      row        <= 5'd0;
      color      <= RESET_COLOR;
      sweep_addr <= '0;
    end else begin
      if (cmd.accept) begin
        col   <= col_next;
        row   <= row_next;
        color <= color_next;
      end
      if (cmd.sweep) begin
        sweep_addr <= sta.sweep_last ? '0 : sweep_addr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_ok <= in_screen;
    end
    if (cmd.load) begin
      if (cmd.read_out) begin
        out_beat.cursor_col    <= col;
        out_beat.cursor_row    <= row;
        out_beat.current_color <= color;
        out_beat.cell_value    <= rd_ok ? rd_data : 16'd0;
        out_beat.position_ok   <= rd_ok;
      end else begin
        out_beat.cursor_col    <= col_next;
        out_beat.cursor_row    <= row_next;
        out_beat.current_color <= color_next;
        out_beat.cell_value    <= 16'd0;
        out_beat.position_ok   <= (in_beat.kind == KIND_SETCUR) && in_screen;
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for text_console_writer_core: directed and random console
// commands checked beat by beat against a predictor of the screen, cursor and color.
// Depends on tcw_pkg and text_console_writer_core.
module tb;
  import tcw_pkg::*;

  class console_scoreboard;
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;

    logic [15:0] cells [SCREEN_COLS * SCREEN_ROWS];
    int          col;
    int          row;
    logic [7:0]  color;
    out_t        expected_results [$];
    int          failures;
    int          checked;

    function new();
      foreach (cells[i]) cells[i] = {RESET_COLOR, SPACE_CODE};
      col = 0;
      row = 0;
      color = RESET_COLOR;
      failures = 0;
      checked = 0;
    endfunction

    function void next_row();
      col = 0;
      row = (row == SCREEN_ROWS - 1) ? 0 : row + 1;
    endfunction

    function bit on_screen(int x, int y);
      return x >= 0 && x < SCREEN_COLS && y >= 0 && y < SCREEN_ROWS;
    endfunction

    function void note_command(in_t c);
      out_t       r;
      int         x;
      int         y;
      logic [7:0] rgb;
      r = '0;
      x = $signed(c.pos_x);
      y = $signed(c.pos_y);
      rgb = '0;
      case (c.kind)
        KIND_WRITE: begin
          if (c.char_code == NEWLINE_CODE) begin
            next_row();
          end else begin
            cells[row * SCREEN_COLS + col] = {color, c.char_code};
            if (col == SCREEN_COLS - 1) next_row();
            else col++;
          end
        end
        KIND_CLEAR: begin
          foreach (cells[i]) cells[i] = {color, SPACE_CODE};
          col = 0;
          row = 0;
        end
        KIND_SETCUR: begin
          if (on_screen(x, y)) begin
            col = x;
            row = y;
            r.position_ok = 1'b1;
          end
        end
        KIND_COLOR: color = c.new_color;
        KIND_RGB: begin
          if (c.red > CHANNEL_LIMIT) rgb |= RGB_RED;
          if (c.green > CHANNEL_LIMIT) rgb |= RGB_GREEN;
          if (c.blue > CHANNEL_LIMIT) rgb |= RGB_BLUE;
          if (rgb != 0) rgb |= RGB_BRIGHT;
          color = rgb;
        end
        KIND_READ: begin
          if (on_screen(x, y)) begin
            r.cell_value = cells[y * SCREEN_COLS + x];
            r.position_ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.cursor_col = 7'(col);
      r.cursor_row = 5'(row);
      r.current_color = color;
      expected_results.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected result beat: col %0d row %0d color %h cell %h ok %b",
                   got.cursor_col, got.cursor_row, got.current_color, got.cell_value,
                   got.position_ok);
        return;
      end
      want = expected_results.pop_front();
      if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
          got.current_color !== want.current_color || got.cell_value !== want.cell_value ||
          got.position_ok !== want.position_ok) begin
        failures++;
        if (failures <= 10)
          $display("Result %0d: exp col %0d row %0d clr %h cell %h ok %b; got %0d %0d %h %h %b",
                   checked, want.cursor_col, want.cursor_row, want.current_color,
                   want.cell_value, want.position_ok, got.cursor_col, got.cursor_row,
                   got.current_color, got.cell_value, got.position_ok);
      end
      checked++;
    endfunction
  endclass

  localparam logic [2:0] KIND_UNUSED_A = 3'd6;
  localparam logic [2:0] KIND_UNUSED_B = 3'd7;
  localparam int QUIET_LIMIT = 10000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_beat;

  console_scoreboard sb;
  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  text_console_writer_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_command(in_beat);
      if (out_valid && !out_stall) sb.check_result(out_beat);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles.", QUIET_LIMIT);
        $display("FAIL text_console_writer_core");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_t make_command(logic [2:0] k, logic [7:0] ch, logic [7:0] x,
                                       logic [7:0] y, logic [7:0] attr, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b);
    in_t c;
    c.kind = k;
    c.char_code = ch;
    c.pos_x = x;
    c.pos_y = y;
    c.new_color = attr;
    c.red = r;
    c.green = g;
    c.blue = b;
    return c;
  endfunction

  function automatic in_t random_command();
    in_t c;
    int  pick;
    c = make_command(KIND_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 48) begin
      if ($urandom_range(0, 15) == 0) c.char_code = NEWLINE_CODE;
    end else if (pick < 68) begin
      c.kind = KIND_READ;
      if ($urandom_range(0, 19) < 17) begin
        c.pos_x = 8'($urandom_range(0, 79));
        c.pos_y = 8'($urandom_range(0, 24));
      end
    end else if (pick < 80) begin
      c.kind = KIND_SETCUR;
      if ($urandom_range(0, 4) < 4) begin
        c.pos_x = 8'($urandom_range(0, 79));
        c.pos_y = 8'($urandom_range(0, 24));
      end
    end else if (pick < 87) begin
      c.kind = KIND_COLOR;
    end else if (pick < 95) begin
      c.kind = KIND_RGB;
    end else if (pick < 98) begin
      c.kind = $urandom_range(0, 1) ? KIND_UNUSED_A : KIND_UNUSED_B;
    end else begin
      c.kind = KIND_CLEAR;
    end
    return c;
  endfunction

  task automatic send_command(input in_t c);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_command(make_command(KIND_READ, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_READ, 8'hFF, 8'd79, 8'd24, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_command(make_command(KIND_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_command(make_command(KIND_WRITE, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_WRITE, NEWLINE_CODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00));
    send_command(make_command(KIND_SETCUR, 8'h00, 8'd79, 8'd24, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_WRITE, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_READ, 8'h00, 8'd79, 8'd24, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_SETCUR, 8'h00, 8'd5, 8'd24, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_WRITE, NEWLINE_CODE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                              8'h00));
    send_command(make_command(KIND_SETCUR, 8'h00, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_SETCUR, 8'h00, 8'h7F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_SETCUR, 8'h00, 8'd80, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_SETCUR, 8'h00, 8'd0, 8'd25, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_READ, 8'h00, 8'hFF, 8'd0, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_READ, 8'h00, 8'd80, 8'd24, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_READ, 8'h00, 8'd0, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_COLOR, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_WRITE, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_RGB, 8'h00, 8'h00, 8'h00, 8'h00, 8'd128, 8'd128, 8'd128));
    send_command(make_command(KIND_RGB, 8'h00, 8'h00, 8'h00, 8'h00, 8'd129, 8'd0, 8'd255));
    send_command(make_command(KIND_RGB, 8'h00, 8'h00, 8'h00, 8'h00, 8'd255, 8'd255, 8'd255));
    send_command(make_command(KIND_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_READ, 8'h00, 8'd3, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00));
    send_command(make_command(KIND_UNUSED_A, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_command(make_command(KIND_UNUSED_B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      idle_on = (phase % 2 == 0);
      repeat (200) send_command(random_command());
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("PASS text_console_writer_core");
    end else begin
      $display("FAIL text_console_writer_core");
    end
    $finish;
  end
endmodule
